/* sv/alx_pkg.sv */
package alx_pkg;

    localparam int TEXT_MAX_DEF   = 32;
    localparam int MAX_TOKENS_DEF = 255;
    localparam int LEN_CAP        = 63;
    localparam int MAX_RES        = 3;
    localparam int QDEPTH         = 4;
    localparam int QCNT_W         = 3;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [3:0] {
        M_BETWEEN   = 4'd0,
        M_IDENT     = 4'd1,
        M_NUMBER    = 4'd2,
        M_CHAR_WAIT = 4'd3,
        M_CHAR_SKIP = 4'd4,
        M_STRING    = 4'd5,
        M_COMMENT   = 4'd6,
        M_AMP       = 4'd7
    } lex_mode_t;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_LINE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        T_NONE   = 3'd0,
        T_TEXT   = 3'd1,
        T_LABEL  = 3'd2,
        T_NUMBER = 3'd3,
        T_STRING = 3'd4
    } tok_type_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_char;
        tok_type_t   token_type;
        logic        address_of;
        logic [5:0]  text_length;
        logic [31:0] number_value;
        logic        truncated;
        logic [7:0]  token_count;
        logic        last;
    } result_t;

    typedef struct packed {
        lex_mode_t   mode;
        logic        amp;
        tok_type_t   typ;
        logic [5:0]  len;
        logic [31:0] val;
        logic        trc;
        logic [7:0]  ltk;
    } lex_state_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic [1:0]            n;
    } res_list_t;

    function automatic logic is_letter(logic [7:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_DOT, CH_UNDER});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]});
    endfunction

    function automatic logic is_eol(logic [7:0] c);
        return (c == CH_NUL) || (c == CH_LF);
    endfunction

    function automatic res_list_t push_rec(res_list_t l, result_t r);
        res_list_t o;
        o = l;
        if (o.n < 2'(MAX_RES))
        begin
            o.res[o.n] = r;
            o.n        = o.n + 2'd1;
        end
        return o;
    endfunction

    function automatic result_t text_rec(logic [7:0] c);
        result_t r;
        r           = '0;
        r.kind      = KIND_TEXT;
        r.text_char = c;
        return r;
    endfunction

    function automatic result_t token_rec(lex_state_t s);
        result_t r;
        r              = '0;
        r.kind         = KIND_TOKEN;
        r.token_type   = s.typ;
        r.address_of   = s.amp;
        r.text_length  = s.len;
        r.number_value = s.val;
        r.truncated    = s.trc;
        return r;
    endfunction

    function automatic result_t line_rec(lex_state_t s);
        result_t r;
        r             = '0;
        r.kind        = KIND_LINE;
        r.token_count = s.ltk;
        return r;
    endfunction

    function automatic lex_state_t clear_tok(lex_state_t s);
        lex_state_t o;
        o      = s;
        o.mode = M_BETWEEN;
        o.amp  = 1'b0;
        o.typ  = T_NONE;
        o.len  = '0;
        o.val  = '0;
        o.trc  = 1'b0;
        return o;
    endfunction

    function automatic lex_state_t tok_done(lex_state_t s, int max_tokens);
        lex_state_t o;
        o = clear_tok(s);
        if (s.ltk < 8'(max_tokens))
        begin
            o.ltk = s.ltk + 8'd1;
        end
        return o;
    endfunction

    function automatic lex_state_t line_done(lex_state_t s);
        lex_state_t o;
        o     = clear_tok(s);
        o.ltk = '0;
        return o;
    endfunction

endpackage

/* sv/alx_core.sv */
module alx_core
    import alx_pkg::*;
#(
    parameter int TEXT_MAX   = TEXT_MAX_DEF,
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_code,
    output res_list_t  recs
);

    localparam int TextLimit = (TEXT_MAX < LEN_CAP) ? TEXT_MAX : LEN_CAP;

    lex_state_t st_reg;
    lex_state_t st_next;

    always_comb
    begin : step_logic
        lex_state_t s;
        res_list_t  l;
        logic       run_between;
        logic       try_begin;
        logic       do_append;
        logic [7:0] c;

        c           = char_code;
        s           = st_reg;
        l           = '0;
        run_between = 1'b0;
        try_begin   = 1'b0;
        do_append   = 1'b0;

        case (st_reg.mode)
            M_IDENT:
            begin
                if (is_letter(c))
                begin
                    do_append = 1'b1;
                end
                else if (c == CH_COLON)
                begin
                    s.typ = T_LABEL;
                    l     = push_rec(l, token_rec(s));
                    s     = tok_done(s, MAX_TOKENS);
                end
                else
                begin
                    l           = push_rec(l, token_rec(s));
                    s           = tok_done(s, MAX_TOKENS);
                    run_between = 1'b1;
                end
            end
            M_NUMBER:
            begin
                if (is_digit(c))
                begin
                    s.val = {st_reg.val[28:0], 3'b000} + {st_reg.val[30:0], 1'b0}
                          + 32'(c - CH_ZERO);
                end
                else
                begin
                    l           = push_rec(l, token_rec(s));
                    s           = tok_done(s, MAX_TOKENS);
                    run_between = 1'b1;
                end
            end
            M_CHAR_WAIT:
            begin
                if (is_eol(c))
                begin
                    l = push_rec(l, token_rec(s));
                    s = tok_done(s, MAX_TOKENS);
                    l = push_rec(l, line_rec(s));
                    s = line_done(s);
                end
                else
                begin
                    s.val  = 32'(c);
                    s.mode = M_CHAR_SKIP;
                end
            end
            M_CHAR_SKIP:
            begin
                l = push_rec(l, token_rec(s));
                s = tok_done(s, MAX_TOKENS);
                if (is_eol(c))
                begin
                    l = push_rec(l, line_rec(s));
                    s = line_done(s);
                end
            end
            M_STRING:
            begin
                if (is_eol(c))
                begin
                    l = push_rec(l, token_rec(s));
                    s = tok_done(s, MAX_TOKENS);
                    l = push_rec(l, line_rec(s));
                    s = line_done(s);
                end
                else if (c == CH_DQUOTE)
                begin
                    l = push_rec(l, token_rec(s));
                    s = tok_done(s, MAX_TOKENS);
                end
                else
                begin
                    do_append = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (is_eol(c))
                begin
                    l = push_rec(l, line_rec(s));
                    s = line_done(s);
                end
            end
            M_AMP:
            begin
                s.mode = M_BETWEEN;
                if (is_eol(c) || c == CH_SPACE || c == CH_TAB || c == CH_SEMI || c == CH_AMP)
                begin
                    l           = push_rec(l, token_rec(s));
                    s           = tok_done(s, MAX_TOKENS);
                    run_between = 1'b1;
                end
                else
                begin
                    try_begin = 1'b1;
                end
            end
            default:
            begin
                s.mode      = M_BETWEEN;
                run_between = 1'b1;
            end
        endcase

        if (run_between)
        begin
            if (is_eol(c))
            begin
                l = push_rec(l, line_rec(s));
                s = line_done(s);
            end
            else if (c == CH_SEMI)
            begin
                s.mode = M_COMMENT;
            end
            else if (c == CH_AMP)
            begin
                s.amp  = 1'b1;
                s.mode = M_AMP;
            end
            else if (c != CH_SPACE && c != CH_TAB)
            begin
                try_begin = 1'b1;
            end
        end

        if (try_begin)
        begin
            if (is_letter(c))
            begin
                s.typ     = T_TEXT;
                s.mode    = M_IDENT;
                do_append = 1'b1;
            end
            else if (is_digit(c))
            begin
                s.typ  = T_NUMBER;
                s.val  = 32'(c - CH_ZERO);
                s.mode = M_NUMBER;
            end
            else if (c == CH_QUOTE)
            begin
                s.typ  = T_NUMBER;
                s.mode = M_CHAR_WAIT;
            end
            else if (c == CH_DQUOTE)
            begin
                s.typ  = T_STRING;
                s.mode = M_STRING;
            end
            else
            begin
                l = push_rec(l, token_rec(s));
                s = tok_done(s, MAX_TOKENS);
            end
        end

        if (do_append)
        begin
            if (s.len < 6'(TextLimit))
            begin
                s.len = s.len + 6'd1;
                l     = push_rec(l, text_rec(c));
            end
            else
            begin
                s.trc = 1'b1;
            end
        end

        if (l.n != 2'd0)
        begin
            l.res[l.n - 2'd1].last = 1'b1;
        end

        st_next = s;
        recs    = l;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

endmodule

/* sv/assembler_line_lexer.sv */
// Channel  Dir  Handshake              Payload
// char     in   char_valid/char_stall  char_code
// rec      out  rec_valid/rec_stall    kind, text_char, token_type, address_of, text_length,
//                                      number_value, truncated, token_count, last
//
// A character is registered on transfer and lexed from that register into zero to three
// records, which enter a four-entry output queue; records leave one per cycle unless stalled.
// Sustained rate is one character per cycle while each character yields at most one record
// and rec_stall is low; extra records can hold the input until the queue has room.
// The character register stalls while the queue cannot take three more records.
// Reset clears the lexer state and empties the queue; no clearing pass.
// rec_stall holds the queue head; char_stall follows queue room and rec_stall.
module assembler_line_lexer
    import alx_pkg::*;
#(
    parameter int TEXT_MAX   = TEXT_MAX_DEF,
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    output logic        rec_valid,
    input  logic        rec_stall,
    output logic [1:0]  kind,
    output logic [7:0]  text_char,
    output logic [2:0]  token_type,
    output logic        address_of,
    output logic [5:0]  text_length,
    output logic [31:0] number_value,
    output logic        truncated,
    output logic [7:0]  token_count,
    output logic        last
);

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    result_t           q_reg [QDEPTH];
    result_t           q_next [QDEPTH];
    logic [QCNT_W-1:0] q_cnt_reg;
    logic [QCNT_W-1:0] q_cnt_next;
    logic [QCNT_W-1:0] base;
    logic              pop;
    logic              room;
    logic              step;
    res_list_t         recs;

    alx_core #(
        .TEXT_MAX   (TEXT_MAX),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (in_char_reg),
        .recs      (recs)
    );

    assign rec_valid  = (q_cnt_reg != '0);
    assign pop        = rec_valid && !rec_stall;
    assign base       = q_cnt_reg - QCNT_W'(pop);
    assign room       = (base <= QCNT_W'(QDEPTH - MAX_RES));
    assign step       = in_valid_reg && room;
    assign char_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall)
        begin
            in_char_reg <= char_code;
        end
    end

    // advance the queue, then append this step's records behind the survivors
    always_comb
    begin : queue_logic
        logic [QCNT_W-1:0] off;

        off = '0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        for (int i = 0; i < QDEPTH - 1; i++)
        begin
            if (pop)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++)
        begin
            off = QCNT_W'(i) - base;
            if (step && QCNT_W'(i) >= base && off < QCNT_W'(recs.n))
            begin
                q_next[i] = recs.res[off[1:0]];
            end
        end
        q_cnt_next = base + (step ? QCNT_W'(recs.n) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign kind         = q_reg[0].kind;
    assign text_char    = q_reg[0].text_char;
    assign token_type   = q_reg[0].token_type;
    assign address_of   = q_reg[0].address_of;
    assign text_length  = q_reg[0].text_length;
    assign number_value = q_reg[0].number_value;
    assign truncated    = q_reg[0].truncated;
    assign token_count  = q_reg[0].token_count;
    assign last         = q_reg[0].last;

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= QCNT_W'(QDEPTH))
        else $error("output queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> ((4'(base) + 4'(recs.n)) <= 4'(QDEPTH)))
        else $error("lexer step would overflow the output queue");

    a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && kind == KIND_LINE) |-> last)
        else $error("line record not marked last");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (in_valid_reg && q_cnt_reg != '0))
        else $error("input stalled with an empty output queue");

endmodule
